// ===== rtl/adsr_eg_pkg.sv =====
// Shared types and constants for the ADSR envelope generator.
// No dependencies; used by every module in rtl/.
package adsr_eg_pkg;

  localparam int LEVEL_FRAC_BITS    = 24;
  localparam int VELOCITY_FRAC_BITS = 15;

  localparam int LVL_W = LEVEL_FRAC_BITS + 1;
  localparam int VEL_W = VELOCITY_FRAC_BITS + 1;

  localparam logic [LVL_W-1:0] LEVEL_ONE    = LVL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [VEL_W-1:0] VELOCITY_ONE = VEL_W'(1) << VELOCITY_FRAC_BITS;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;
  localparam logic [1:0] OP_RESET    = 2'd3;

  localparam logic [1:0] REG_ATTACK_STEP   = 2'd0;
  localparam logic [1:0] REG_DECAY_STEP    = 2'd1;
  localparam logic [1:0] REG_SUSTAIN_LEVEL = 2'd2;
  localparam logic [1:0] REG_RELEASE_SCALE = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [VEL_W-1:0] note_velocity;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] envelope_out;
    logic [2:0]       phase_now;
  } out_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] attack_step;
    logic [LVL_W-1:0] decay_step;
    logic [LVL_W-1:0] sustain_level;
    logic [LVL_W-1:0] release_scale;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [VEL_W-1:0] velocity;
    phase_t           phase;
  } scale_req_t;

endpackage

// ===== rtl/adsr_envelope_generator_core.sv =====
// Linear ADSR envelope generator, top level: input register, configuration
// registers, envelope state and output scaling. Depends on adsr_eg_pkg,
// adsr_eg_state and adsr_eg_scale.
//
// One item is taken per clock while in_stall is low. An item waits in the input
// register, then updates the envelope state; a sample tick's result then passes
// the holding register and the output register. Only sample ticks produce results.
// The state update is one add and compare, and a 25x25 multiply for the release
// step on note off; the velocity multiply has its own stage. Configuration
// writes take effect at once and are meant for an idle block.
module adsr_envelope_generator_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  adsr_eg_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output adsr_eg_pkg::out_item_t out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [adsr_eg_pkg::LVL_W-1:0] cfg_data
);

  adsr_eg_pkg::cfg_t       cfg_r;
  logic                    in_v_r;
  adsr_eg_pkg::in_item_t   in_r;
  logic                    fire;
  logic                    req_valid;
  logic                    req_ready;
  adsr_eg_pkg::scale_req_t req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step   <= adsr_eg_pkg::LVL_W'(69905);
      cfg_r.decay_step    <= adsr_eg_pkg::LVL_W'(349);
      cfg_r.sustain_level <= adsr_eg_pkg::LVL_W'(11744051);
      cfg_r.release_scale <= adsr_eg_pkg::LVL_W'(35);
    end else if (cfg_we) begin
      case (cfg_index)
        adsr_eg_pkg::REG_ATTACK_STEP:   cfg_r.attack_step   <= cfg_data;
        adsr_eg_pkg::REG_DECAY_STEP:    cfg_r.decay_step    <= cfg_data;
        adsr_eg_pkg::REG_SUSTAIN_LEVEL: cfg_r.sustain_level <= cfg_data;
        adsr_eg_pkg::REG_RELEASE_SCALE: cfg_r.release_scale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a tick needs room downstream, other opcodes only touch state
  assign fire     = in_v_r && ((in_r.opcode != adsr_eg_pkg::OP_TICK) || req_ready);
  assign in_stall = in_v_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_v_r || fire) begin
      in_v_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  adsr_eg_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step_en   (fire),
    .item      (in_r),
    .req_valid (req_valid),
    .req       (req)
  );

  adsr_eg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_tick_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> req_ready) else $error("tick transfer with full holding stage");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_v_r) else $error("stalled item lost from input register");

  a_fire_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> in_v_r) else $error("state update without item");

endmodule

// ===== rtl/adsr_eg_state.sv =====
// Envelope state: phase, level, held velocity and release step, updated once
// per transfer. Depends on adsr_eg_pkg.
module adsr_eg_state (
  input  logic                   clk,
  input  logic                   rst_n,
  input  adsr_eg_pkg::cfg_t      cfg,
  input  logic                   step_en,
  input  adsr_eg_pkg::in_item_t  item,
  output logic                   req_valid,
  output adsr_eg_pkg::scale_req_t req
);

  localparam int LW = adsr_eg_pkg::LVL_W;
  localparam int VW = adsr_eg_pkg::VEL_W;
  localparam int FB = adsr_eg_pkg::LEVEL_FRAC_BITS;
  localparam int PW = 2 * LW;
  localparam logic [LW-1:0] ONE  = adsr_eg_pkg::LEVEL_ONE;
  localparam logic [VW-1:0] VONE = adsr_eg_pkg::VELOCITY_ONE;

  adsr_eg_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [VW-1:0] vel_r, vel_nxt;
  logic [LW-1:0] rstep_r, rstep_nxt;

  logic [LW-1:0] sus;
  logic [LW-1:0] rscale;
  logic [LW:0]   atk_sum;
  logic [LW:0]   dec_lim;
  logic [PW-1:0] rel_rnd;

  always_comb begin
    sus     = (cfg.sustain_level > ONE) ? ONE : cfg.sustain_level;
    rscale  = (cfg.release_scale > ONE) ? ONE : cfg.release_scale;
    atk_sum = {1'b0, level_r} + {1'b0, cfg.attack_step};
    dec_lim = {1'b0, sus} + {1'b0, cfg.decay_step};
    rel_rnd = PW'(level_r) * PW'(rscale) + PW'(ONE - LW'(1));

    phase_nxt = phase_r;
    level_nxt = level_r;
    vel_nxt   = vel_r;
    rstep_nxt = rstep_r;

    case (item.opcode)
      adsr_eg_pkg::OP_NOTE_ON: begin
        vel_nxt   = (item.note_velocity > VONE) ? VONE : item.note_velocity;
        phase_nxt = adsr_eg_pkg::PH_ATTACK;
      end
      adsr_eg_pkg::OP_NOTE_OFF: begin
        rstep_nxt = rel_rnd[FB+LW-1:FB];
        phase_nxt = adsr_eg_pkg::PH_RELEASE;
      end
      adsr_eg_pkg::OP_RESET: begin
        phase_nxt = adsr_eg_pkg::PH_IDLE;
        level_nxt = '0;
      end
      adsr_eg_pkg::OP_TICK: begin
        case (phase_r)
          adsr_eg_pkg::PH_ATTACK: begin
            if (atk_sum >= {1'b0, ONE}) begin
              level_nxt = ONE;
              phase_nxt = adsr_eg_pkg::PH_DECAY;
            end else begin
              level_nxt = atk_sum[LW-1:0];
            end
          end
          adsr_eg_pkg::PH_DECAY: begin
            if ({1'b0, level_r} <= dec_lim) begin
              level_nxt = sus;
              phase_nxt = adsr_eg_pkg::PH_SUSTAIN;
            end else begin
              level_nxt = level_r - cfg.decay_step;
            end
          end
          adsr_eg_pkg::PH_SUSTAIN: begin
            level_nxt = sus;
          end
          adsr_eg_pkg::PH_RELEASE: begin
            if (level_r <= rstep_r) begin
              level_nxt = '0;
              phase_nxt = adsr_eg_pkg::PH_IDLE;
            end else begin
              level_nxt = level_r - rstep_r;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    req_valid    = step_en && (item.opcode == adsr_eg_pkg::OP_TICK);
    req.level    = (phase_r == adsr_eg_pkg::PH_IDLE) ? '0 : level_nxt;
    req.velocity = vel_r;
    req.phase    = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= adsr_eg_pkg::PH_IDLE;
      level_r <= '0;
      vel_r   <= '0;
      rstep_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      vel_r   <= vel_nxt;
      rstep_r <= rstep_nxt;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= ONE) else $error("level above unity");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == adsr_eg_pkg::PH_IDLE) |-> (level_r == '0))
    else $error("idle with nonzero level");

  a_rstep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rstep_r <= ONE) else $error("release step above unity");

  a_vel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vel_r <= VONE) else $error("held velocity above unity");

endmodule

// ===== rtl/adsr_eg_scale.sv =====
// Back end: holding register for a tick result, velocity multiply and the
// output register. Depends on adsr_eg_pkg.
module adsr_eg_scale (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  input  adsr_eg_pkg::scale_req_t req,
  output logic                    req_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output adsr_eg_pkg::out_item_t  out_data
);

  localparam int LW = adsr_eg_pkg::LVL_W;
  localparam int VW = adsr_eg_pkg::VEL_W;
  localparam int FB = adsr_eg_pkg::VELOCITY_FRAC_BITS;
  localparam int PW = LW + VW;

  logic                    mid_v_r;
  adsr_eg_pkg::scale_req_t mid_r;
  logic                    out_v_r;
  adsr_eg_pkg::out_item_t  out_r;
  adsr_eg_pkg::out_item_t  out_nxt;
  logic                    out_take;
  logic [PW-1:0]           prod;

  assign out_take  = !out_v_r || !out_stall;
  assign req_ready = !mid_v_r || out_take;

  always_comb begin
    prod                 = PW'(mid_r.level) * PW'(mid_r.velocity);
    out_nxt.envelope_out = prod[FB+LW-1:FB];
    out_nxt.phase_now    = mid_r.phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (req_ready) begin
        mid_v_r <= req_valid;
      end
      if (out_take) begin
        out_v_r <= mid_v_r;
      end
    end
    if (req_valid && req_ready) begin
      mid_r <= req;
    end
    if (mid_v_r && out_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== bench/tb_adsr_envelope_generator_core.sv =====
// Self-checking bench for adsr_envelope_generator_core: drives note phrases and
// register settings, tracks the envelope in a scoreboard and checks every tick.
// Depends on adsr_eg_pkg and the RTL top level only.
module tb_adsr_envelope_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [adsr_eg_pkg::LVL_W-1:0] REG_MAX = '1;
  localparam int CYCLE_LIMIT = 400000;

  class envelope_tracker;
    logic [adsr_eg_pkg::LVL_W-1:0] attack_step;
    logic [adsr_eg_pkg::LVL_W-1:0] decay_step;
    logic [adsr_eg_pkg::LVL_W-1:0] sustain_level;
    logic [adsr_eg_pkg::LVL_W-1:0] release_scale;
    adsr_eg_pkg::phase_t           phase;
    logic [adsr_eg_pkg::LVL_W:0]   level;
    logic [adsr_eg_pkg::VEL_W-1:0] held_vel;
    logic [adsr_eg_pkg::LVL_W-1:0] rel_step;
    adsr_eg_pkg::out_item_t        pending_levels[$];
    int                            failures;

    function new();
      attack_step   = 25'd69905;
      decay_step    = 25'd349;
      sustain_level = 25'd11744051;
      release_scale = 25'd35;
      phase         = adsr_eg_pkg::PH_IDLE;
      level         = '0;
      held_vel      = '0;
      rel_step      = '0;
      failures      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [adsr_eg_pkg::LVL_W-1:0] val);
      case (idx)
        adsr_eg_pkg::REG_ATTACK_STEP:   attack_step = val;
        adsr_eg_pkg::REG_DECAY_STEP:    decay_step = val;
        adsr_eg_pkg::REG_SUSTAIN_LEVEL: sustain_level = val;
        default:                        release_scale = val;
      endcase
    endfunction

    function logic [63:0] clamp_unity(logic [63:0] v);
      return (v > 64'(adsr_eg_pkg::LEVEL_ONE)) ? 64'(adsr_eg_pkg::LEVEL_ONE) : v;
    endfunction

    function void take_item(adsr_eg_pkg::in_item_t it);
      logic [63:0]            one;
      logic [63:0]            sus;
      logic [63:0]            prod;
      logic [63:0]            shifted;
      adsr_eg_pkg::out_item_t r;
      one = 64'(adsr_eg_pkg::LEVEL_ONE);
      sus = clamp_unity(64'(sustain_level));
      case (it.opcode)
        adsr_eg_pkg::OP_NOTE_ON: begin
          held_vel = (it.note_velocity > adsr_eg_pkg::VELOCITY_ONE) ?
                     adsr_eg_pkg::VELOCITY_ONE : it.note_velocity;
          phase = adsr_eg_pkg::PH_ATTACK;
        end
        adsr_eg_pkg::OP_NOTE_OFF: begin
          prod = 64'(level) * clamp_unity(64'(release_scale));
          shifted = (prod + one - 64'd1) >> adsr_eg_pkg::LEVEL_FRAC_BITS;
          rel_step = shifted[adsr_eg_pkg::LVL_W-1:0];
          phase = adsr_eg_pkg::PH_RELEASE;
        end
        adsr_eg_pkg::OP_RESET: begin
          phase = adsr_eg_pkg::PH_IDLE;
          level = '0;
        end
        default: begin
          if (phase == adsr_eg_pkg::PH_IDLE) begin
            r.envelope_out = '0;
            r.phase_now = adsr_eg_pkg::PH_IDLE;
          end else begin
            case (phase)
              adsr_eg_pkg::PH_ATTACK: begin
                level = level + (adsr_eg_pkg::LVL_W+1)'(attack_step);
                if (64'(level) >= one) begin
                  level = (adsr_eg_pkg::LVL_W+1)'(adsr_eg_pkg::LEVEL_ONE);
                  phase = adsr_eg_pkg::PH_DECAY;
                end
              end
              adsr_eg_pkg::PH_DECAY: begin
                if (64'(level) <= sus + 64'(decay_step)) begin
                  level = sus[adsr_eg_pkg::LVL_W:0];
                  phase = adsr_eg_pkg::PH_SUSTAIN;
                end else begin
                  level = level - (adsr_eg_pkg::LVL_W+1)'(decay_step);
                end
              end
              adsr_eg_pkg::PH_SUSTAIN: level = sus[adsr_eg_pkg::LVL_W:0];
              default: begin
                if (level <= (adsr_eg_pkg::LVL_W+1)'(rel_step)) begin
                  level = '0;
                  phase = adsr_eg_pkg::PH_IDLE;
                end else begin
                  level = level - (adsr_eg_pkg::LVL_W+1)'(rel_step);
                end
              end
            endcase
            prod = 64'(level) * 64'(held_vel);
            shifted = prod >> adsr_eg_pkg::VELOCITY_FRAC_BITS;
            r.envelope_out = shifted[adsr_eg_pkg::LVL_W-1:0];
            r.phase_now = phase;
          end
          pending_levels.push_back(r);
        end
      endcase
    endfunction

    function void check_level(adsr_eg_pkg::out_item_t got);
      adsr_eg_pkg::out_item_t want;
      if (pending_levels.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected transfer: env %0d phase %0d", got.envelope_out, got.phase_now);
      end else begin
        want = pending_levels.pop_front();
        if (got.envelope_out !== want.envelope_out || got.phase_now !== want.phase_now) begin
          failures++;
          if (failures <= 10)
            $display("level mismatch: expected env %0d phase %0d, got env %0d phase %0d",
                     want.envelope_out, want.phase_now, got.envelope_out, got.phase_now);
        end
      end
    endfunction

    function int outstanding();
      return pending_levels.size();
    endfunction
  endclass

  bit                            clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  adsr_eg_pkg::in_item_t         in_data;
  logic                          out_valid;
  logic                          out_stall;
  adsr_eg_pkg::out_item_t        out_data;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [adsr_eg_pkg::LVL_W-1:0] cfg_data;

  envelope_tracker      tracker;
  bit                   calm;
  int                   cycles;

  adsr_envelope_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_item(in_data);
      if (out_valid && !out_stall) tracker.check_level(out_data);
    end
  end

  function automatic logic [adsr_eg_pkg::VEL_W-1:0] draw_velocity();
    if ($urandom_range(0, 1) == 0) return adsr_eg_pkg::VEL_W'($urandom);
    return adsr_eg_pkg::VEL_W'($urandom_range(0, 32768));
  endfunction

  function automatic logic [adsr_eg_pkg::LVL_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return adsr_eg_pkg::LVL_W'(1);
      2:       return REG_MAX;
      3:       return adsr_eg_pkg::LEVEL_ONE;
      default: return adsr_eg_pkg::LVL_W'(adsr_eg_pkg::LEVEL_ONE / $urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [adsr_eg_pkg::LVL_W-1:0] pick_sustain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return adsr_eg_pkg::LEVEL_ONE;
      2:       return REG_MAX;
      default: return adsr_eg_pkg::LVL_W'($urandom_range(0, 32'(adsr_eg_pkg::LEVEL_ONE)));
    endcase
  endfunction

  // caller sits at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic [1:0] op, logic [adsr_eg_pkg::VEL_W-1:0] vel);
    int                    gap;
    adsr_eg_pkg::in_item_t it;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.opcode = op;
    it.note_velocity = vel;
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [adsr_eg_pkg::LVL_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_regs(logic [adsr_eg_pkg::LVL_W-1:0] atk,
                              logic [adsr_eg_pkg::LVL_W-1:0] dec,
                              logic [adsr_eg_pkg::LVL_W-1:0] sus,
                              logic [adsr_eg_pkg::LVL_W-1:0] rel);
    write_reg(adsr_eg_pkg::REG_ATTACK_STEP, atk);
    write_reg(adsr_eg_pkg::REG_DECAY_STEP, dec);
    write_reg(adsr_eg_pkg::REG_SUSTAIN_LEVEL, sus);
    write_reg(adsr_eg_pkg::REG_RELEASE_SCALE, rel);
  endtask

  // drain: no transfer pending, plus room for result-free items still in flight
  task automatic settle();
    in_valid = 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic phrase_item(logic [1:0] op, inout int count);
    logic [1:0] code;
    code = ($urandom_range(0, 9) == 0) ? 2'($urandom) : op;
    send_item(code, draw_velocity());
    count++;
  endtask

  task automatic play_phrase(inout int count);
    int hold_ticks;
    int tail_ticks;
    hold_ticks = $urandom_range(0, 30);
    tail_ticks = $urandom_range(0, 25);
    phrase_item(adsr_eg_pkg::OP_NOTE_ON, count);
    repeat (hold_ticks) phrase_item(adsr_eg_pkg::OP_TICK, count);
    phrase_item(adsr_eg_pkg::OP_NOTE_OFF, count);
    repeat (tail_ticks) phrase_item(adsr_eg_pkg::OP_TICK, count);
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int count;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = adsr_eg_pkg::REG_ATTACK_STEP;
    cfg_data = '0;
    calm = 1'b0;
    cycles = 0;
    tracker = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: idle ticks, note off while idle, over-unity velocity, reset op
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_NOTE_OFF, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_NOTE_ON, 16'hFFFF);
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_RESET, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());

    // one-tick attack, instant decay, sustain and release above unity
    settle();
    program_regs(adsr_eg_pkg::LEVEL_ONE, REG_MAX, REG_MAX, REG_MAX);
    send_item(adsr_eg_pkg::OP_NOTE_ON, 16'h8000);
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_NOTE_OFF, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_NOTE_ON, 16'h0001);
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());

    // all zero: attack from full level, stalled release at full level, stalled attack at zero
    settle();
    program_regs('0, '0, '0, '0);
    send_item(adsr_eg_pkg::OP_NOTE_ON, 16'h7FFF);
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_NOTE_OFF, draw_velocity());
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());
    send_item(adsr_eg_pkg::OP_RESET, draw_velocity());
    send_item(adsr_eg_pkg::OP_NOTE_ON, 16'h0000);
    send_item(adsr_eg_pkg::OP_TICK, draw_velocity());

    for (int p = 0; p < 8; p++) begin
      settle();
      calm = (p % 3 == 1);
      program_regs(pick_step(), pick_step(), pick_sustain(), pick_step());
      count = 0;
      while (count < 50) play_phrase(count);
    end

    calm = 1'b0;
    in_valid = 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (tracker.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/adsr_eg_pkg.sv
rtl/adsr_eg_state.sv
rtl/adsr_eg_scale.sv
rtl/adsr_envelope_generator_core.sv
bench/tb_adsr_envelope_generator_core.sv
